[hw/rtl/lits_pkg.sv]
// Shared types and constants of the LCD init-table sequencer.
package lits_pkg;

  // Action codes carried in the high byte of a table word
  localparam logic [7:0] ACT_CMD     = 8'h00;
  localparam logic [7:0] ACT_DELAY   = 8'h01;
  localparam logic [7:0] ACT_CMD_ALT = 8'h02;
  localparam logic [7:0] ACT_PARAM   = 8'h03;

  // Result kinds
  localparam logic [1:0] KIND_CMD   = 2'd0;
  localparam logic [1:0] KIND_PARAM = 2'd1;
  localparam logic [1:0] KIND_DELAY = 2'd2;

  // Count field of a job covers the largest supported parameter buffer (32 bytes)
  localparam int unsigned JOB_CNT_W = 6;

  // Depth of the job queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic {
    JOB_DELAY,
    JOB_FLUSH
  } lits_job_e;

  // One unit of work for the back end: a delay request or a packet flush
  typedef struct packed {
    lits_job_e            kind;
    logic [7:0]           value;  // delay in ms, or command byte of the packet
    logic [JOB_CNT_W-1:0] count;  // parameter bytes in the packet
    logic                 bank;   // parameter buffer bank holding them
    logic                 last;   // last result of its table word
    logic                 done;   // last result of the whole table
  } lits_job_t;

  // Bank release from back to front once a flush has read all its bytes
  typedef struct packed {
    logic valid;
    logic bank;
  } lits_clr_t;

endpackage

[hw/rtl/lits_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lits_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/lits_front.sv]
// Front end: takes table words, tracks the pending packet and issues jobs.
module lits_front import lits_pkg::*; #(
  parameter int unsigned PARAM_BYTES = 32,
  parameter int unsigned IDX_W       = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [15:0]      table_word_i,
  input  logic             final_word_i,
  output logic             q_push_o,
  output lits_job_t        q_job_o,
  input  logic             q_full_i,
  output logic             ram_we_o,
  output logic [IDX_W:0]   ram_waddr_o,
  output logic [7:0]       ram_wdata_o,
  input  lits_clr_t        clr_i
);

  localparam int unsigned CNT_W = $clog2(PARAM_BYTES + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACT,
    S_FIN
  } state_e;

  state_e           state_q, state_d;
  logic [15:0]      word_q, word_d;
  logic             final_q, final_d;
  logic             at_start_q, at_start_d;
  logic [7:0]       pend_q, pend_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             bank_q, bank_d;
  logic [1:0]       busy_q, busy_d;

  logic [7:0] action;
  logic [7:0] value;
  logic       advance;

  always_comb begin
    action      = word_q[15:8];
    value       = word_q[7:0];
    advance     = 1'b0;
    state_d     = state_q;
    word_d      = word_q;
    final_d     = final_q;
    at_start_d  = at_start_q;
    pend_d      = pend_q;
    cnt_d       = cnt_q;
    bank_d      = bank_q;
    q_push_o    = 1'b0;
    q_job_o.kind  = JOB_FLUSH;
    q_job_o.value = pend_q;
    q_job_o.count = JOB_CNT_W'(cnt_q);
    q_job_o.bank  = bank_q;
    q_job_o.last  = 1'b1;
    q_job_o.done  = 1'b0;
    ram_we_o    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          word_d  = table_word_i;
          final_d = final_word_i;
          state_d = S_ACT;
        end
      end
      S_ACT: begin
        advance = 1'b1;
        case (action)
          ACT_CMD, ACT_CMD_ALT: begin
            if (!at_start_q) begin
              if (q_full_i) begin
                advance = 1'b0;
              end else begin
                q_push_o     = 1'b1;
                q_job_o.last = !final_q;
                bank_d       = !bank_q;
              end
            end
            if (advance) begin
              pend_d = value;
              cnt_d  = '0;
            end
          end
          ACT_DELAY: begin
            q_job_o.kind  = JOB_DELAY;
            q_job_o.value = value;
            q_job_o.last  = !final_q;
            if (q_full_i) begin
              advance = 1'b0;
            end else begin
              q_push_o = 1'b1;
            end
          end
          ACT_PARAM: begin
            // drop the byte once the buffer is full
            if (cnt_q < CNT_W'(PARAM_BYTES)) begin
              if (busy_q[bank_q]) begin
                advance = 1'b0;
              end else begin
                ram_we_o = 1'b1;
                cnt_d    = cnt_q + 1'b1;
              end
            end
          end
          default: ;
        endcase
        if (advance) begin
          at_start_d = 1'b0;
          state_d    = final_q ? S_FIN : S_IDLE;
        end
      end
      S_FIN: begin
        if (!q_full_i) begin
          q_push_o     = 1'b1;
          q_job_o.done = 1'b1;
          bank_d       = !bank_q;
          pend_d       = '0;
          cnt_d        = '0;
          at_start_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    busy_d = busy_q;
    if (clr_i.valid) begin
      busy_d[clr_i.bank] = 1'b0;
    end
    if (q_push_o && (q_job_o.kind == JOB_FLUSH) && (cnt_q != '0)) begin
      busy_d[bank_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      word_q     <= '0;
      final_q    <= 1'b0;
      at_start_q <= 1'b1;
      pend_q     <= '0;
      cnt_q      <= '0;
      bank_q     <= 1'b0;
      busy_q     <= '0;
    end else begin
      state_q    <= state_d;
      word_q     <= word_d;
      final_q    <= final_d;
      at_start_q <= at_start_d;
      pend_q     <= pend_d;
      cnt_q      <= cnt_d;
      bank_q     <= bank_d;
      busy_q     <= busy_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign ram_waddr_o = {bank_q, cnt_q[IDX_W-1:0]};
  assign ram_wdata_o = value;

endmodule

[hw/rtl/lits_fifo.sv]
// Job queue between the front and back ends.
module lits_fifo import lits_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  lits_job_t push_job_i,
  output logic      full_o,
  input  logic      pop_i,
  output lits_job_t head_job_o,
  output logic      empty_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  lits_job_t        mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   fill_q;

  logic do_push, do_pop;

  assign full_o     = (fill_q == (PTR_W + 1)'(QUEUE_DEPTH));
  assign empty_o    = (fill_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign head_job_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/lits_back.sv]
// Back end: runs jobs and drives the registered result channel.
module lits_back import lits_pkg::*; #(
  parameter int unsigned IDX_W = 5
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  lits_job_t      q_job_i,
  output logic           q_pop_o,
  output logic           ram_re_o,
  output logic [IDX_W:0] ram_raddr_o,
  input  logic [7:0]     ram_rdata_i,
  output lits_clr_t      clr_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [1:0]     out_kind_o,
  output logic [7:0]     out_value_o,
  output logic           run_last_o,
  output logic           table_done_o
);

  typedef enum logic [1:0] {
    B_IDLE,
    B_CMD,
    B_PARAM
  } state_e;

  state_e           state_q, state_d;
  lits_job_t        job_q, job_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  logic [1:0]       kind_q, kind_d;
  logic [7:0]       value_q, value_d;
  logic             last_q, last_d;
  logic             done_q, done_d;

  logic slot_free;
  logic last_byte;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign last_byte = ((JOB_CNT_W'(idx_q) + JOB_CNT_W'(1)) == job_q.count);

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    idx_d       = idx_q;
    kind_d      = kind_q;
    value_d     = value_q;
    last_d      = last_q;
    done_d      = done_q;
    out_valid_d = out_valid_q && out_stall_i;
    q_pop_o     = 1'b0;
    ram_re_o    = 1'b0;
    ram_raddr_o = {job_q.bank, idx_q};
    clr_o.valid = 1'b0;
    clr_o.bank  = job_q.bank;

    case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          if (q_job_i.kind == JOB_DELAY) begin
            if (slot_free) begin
              q_pop_o     = 1'b1;
              out_valid_d = 1'b1;
              kind_d      = KIND_DELAY;
              value_d     = q_job_i.value;
              last_d      = q_job_i.last;
              done_d      = q_job_i.done;
            end
          end else begin
            q_pop_o = 1'b1;
            job_d   = q_job_i;
            state_d = B_CMD;
          end
        end
      end
      B_CMD: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          kind_d      = KIND_CMD;
          value_d     = job_q.value;
          last_d      = job_q.last && (job_q.count == '0);
          done_d      = job_q.done && (job_q.count == '0);
          if (job_q.count == '0) begin
            state_d = B_IDLE;
          end else begin
            // fetch the first parameter byte alongside the command byte
            ram_re_o    = 1'b1;
            ram_raddr_o = {job_q.bank, {IDX_W{1'b0}}};
            idx_d       = '0;
            state_d     = B_PARAM;
          end
        end
      end
      B_PARAM: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          kind_d      = KIND_PARAM;
          value_d     = ram_rdata_i;
          last_d      = job_q.last && last_byte;
          done_d      = job_q.done && last_byte;
          if (last_byte) begin
            clr_o.valid = 1'b1;
            state_d     = B_IDLE;
          end else begin
            ram_re_o    = 1'b1;
            ram_raddr_o = {job_q.bank, idx_q + IDX_W'(1)};
            idx_d       = idx_q + IDX_W'(1);
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      job_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= KIND_CMD;
      value_q     <= '0;
      last_q      <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      job_q       <= job_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      kind_q      <= kind_d;
      value_q     <= value_d;
      last_q      <= last_d;
      done_q      <= done_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_kind_o   = kind_q;
  assign out_value_o  = value_q;
  assign run_last_o   = last_q;
  assign table_done_o = done_q;

endmodule

[hw/rtl/lcd_init_table_sequencer_top.sv]
// Top level of the LCD init-table sequencer: front end, job queue, buffer RAM, back end.
//
// Usage: feed the panel init table one 16-bit word per request on the input
// channel (in_valid_i / in_stall_o), with final_word_i set on the last word.
// Each request yields zero or more results on the output channel
// (out_valid_o / out_stall_i): command bytes, parameter bytes and delay
// requests, with run_last_o on the last result of a word and table_done_o
// on the final result of the table.
// Input: the front takes a word through an accept / act sequence, with a
// flush step added when final_word_i is set, and takes no new word until it
// is through. It holds off while the job queue is full, or while a parameter
// write targets a buffer bank that the back end has not finished reading.
// Output order: a delay job goes from the job queue straight into the result
// register; a flush job is first taken into the back end's job register,
// then its command byte is registered, and its parameter bytes follow one
// per cycle from the buffer RAM while out_stall_i is low.
// Stall: the result register holds while out_stall_i is high; the job queue
// lets the front keep taking words meanwhile until it fills.
// Reset: asynchronous, active low; the table restarts with command 0 and an
// empty buffer. The buffer RAM needs no clearing, only held bytes are read.
module lcd_init_table_sequencer_top import lits_pkg::*; #(
  parameter int unsigned PARAM_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] table_word_i,
  input  logic        final_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  out_kind_o,
  output logic [7:0]  out_value_o,
  output logic        run_last_o,
  output logic        table_done_o
);

  // Two buffer banks: front fills one while back drains the other
  localparam int unsigned IDX_W     = (PARAM_BYTES > 1) ? $clog2(PARAM_BYTES) : 1;
  localparam int unsigned RAM_DEPTH = 2 ** (IDX_W + 1);

  logic           q_push;
  lits_job_t      q_push_job;
  logic           q_full;
  logic           q_pop;
  lits_job_t      q_head_job;
  logic           q_empty;
  logic           ram_we;
  logic [IDX_W:0] ram_waddr;
  logic [7:0]     ram_wdata;
  logic           ram_re;
  logic [IDX_W:0] ram_raddr;
  logic [7:0]     ram_rdata;
  lits_clr_t      bank_clr;

  // Front: classify words, hold the pending packet, issue jobs
  lits_front #(
    .PARAM_BYTES (PARAM_BYTES),
    .IDX_W       (IDX_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .table_word_i (table_word_i),
    .final_word_i (final_word_i),
    .q_push_o     (q_push),
    .q_job_o      (q_push_job),
    .q_full_i     (q_full),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .clr_i        (bank_clr)
  );

  // Short job queue decoupling front and back
  lits_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (q_push_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .head_job_o (q_head_job),
    .empty_o    (q_empty)
  );

  // Parameter byte buffer, addressed by {bank, index}
  lits_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_param_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Back: emit delays and packets through the result register
  lits_back #(
    .IDX_W (IDX_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_job_i      (q_head_job),
    .q_pop_o      (q_pop),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .clr_o        (bank_clr),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_kind_o   (out_kind_o),
    .out_value_o  (out_value_o),
    .run_last_o   (run_last_o),
    .table_done_o (table_done_o)
  );

endmodule

[hw/rtl/lits_checker.sv]
// Port-level checks of the LCD init-table sequencer, bound to its top level.
module lits_checker import lits_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [15:0] table_word_i,
  input logic        final_word_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  out_kind_o,
  input logic [7:0]  out_value_o,
  input logic        run_last_o,
  input logic        table_done_o
);

  // End of table is always the end of its word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && table_done_o |-> run_last_o)
    else $error("table_done without run_last");

  // The table ends with a flushed packet byte, never a delay
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && table_done_o |-> out_kind_o != KIND_DELAY)
    else $error("table_done on a delay result");

  // A taken request is worked on before the next one is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken in back-to-back cycles");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_kind_o)
      && $stable(out_value_o) && $stable(run_last_o) && $stable(table_done_o))
    else $error("stalled result changed");

endmodule

bind lcd_init_table_sequencer_top lits_checker u_lits_checker (.*);
